[rtl/core/hps_pkg.sv]
`timescale 1ns / 1ps
package hps_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int PATTERN_COUNT = 8;

    // phase offsets in table steps, 120 degrees apart
    localparam logic [7:0] PHASE_A_OFS = 8'd171;
    localparam logic [7:0] PHASE_C_OFS = 8'd85;

    localparam logic signed [32:0] INTEG_LIMIT = 33'sd1048576;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_LEAD_ANGLE = 3'd2,
        CFG_REF_ANGLE  = 3'd3,
        CFG_PWM_MID    = 3'd4,
        CFG_STALL      = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_TABLE = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVAL, ST_MULP, ST_MULI, ST_CORR, ST_INTERP, ST_ANGLE,
        ST_ADDR, ST_RD0, ST_RD1, ST_LERP, ST_VSUM, ST_SCALE, ST_STORE, ST_OUT
    } t_state;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        timer_now;
        logic [2:0]         hall_pattern;
        logic [7:0]         drive_level;
        logic [7:0]         table_index;
        logic signed [15:0] table_value;
    } t_in;

    typedef struct packed {
        logic [15:0] pwm_phase_a;
        logic [15:0] pwm_phase_b;
        logic [15:0] pwm_phase_c;
        logic        sine_mode;
        logic [15:0] period_ticks;
        logic [15:0] final_angle;
        logic        lead_update_pulse;
    } t_out;

    // hall pattern angle, Q8.8 in table steps (256 steps per turn)
    function automatic logic [15:0] pattern_angle(input logic [2:0] pat);
        logic [15:0] a;
        case (pat)
            3'd1:    a = 16'(24 << 8);
            3'd2:    a = 16'(107 << 8);
            3'd3:    a = 16'(66 << 8);
            3'd4:    a = 16'(195 << 8);
            3'd5:    a = 16'(235 << 8);
            3'd6:    a = 16'(152 << 8);
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // expected successor in the sequence 1,3,2,6,4,5
    function automatic logic [2:0] next_pattern(input logic [2:0] pat);
        logic [2:0] n;
        case (pat)
            3'd0:    n = 3'd3;
            3'd1:    n = 3'd3;
            3'd2:    n = 3'd6;
            3'd3:    n = 3'd2;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd1;
            3'd6:    n = 3'd4;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/hps_ram.sv]
`timescale 1ns / 1ps
module hps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/hall_pll_sine_pwm.sv]
`timescale 1ns / 1ps
// control tick: pll and angle work (EVAL, MULP, MULI, CORR on a valid edge, then INTERP, ANGLE),
// then ADDR, RD0, RD1, LERP, VSUM, SCALE, STORE per phase, then the result beat is held in OUT
// input ready again the cycle after the result beat is taken
// table write: written while idle, input ready again the next cycle, no result
// the work is sequenced through one shared 33x17 multiplier and the single table read port
// synchronous active-low reset clears pll state and loads register defaults, not the table
module hall_pll_sine_pwm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hps_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hps_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import hps_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_prop_gain, r_integ_gain, r_lead_angle, r_pwm_mid, r_stall;
    logic [7:0]  r_ref_angle;

    // estimator state
    logic [31:0] r_rotor, r_edge_pos, r_vel, r_integ;
    logic [15:0] r_edge_time, r_turn_ref_time, r_turn_period;
    logic [2:0]  r_prior;
    logic        r_turn_ref_valid, r_interp;

    // working registers
    t_in         r_in;
    t_out        r_out;
    logic [15:0] r_elapsed, r_final, r_y0, r_v;
    logic [31:0] r_err, r_dp;
    logic [16:0] r_diff;
    logic [1:0]  r_phase;
    logic        r_edge_ok;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] r_prod;

    // table port
    logic [TABLE_AW-1:0] ram_raddr, base_addr;
    logic [15:0]         ram_rdata;
    logic                in_fire, tbl_we;

    logic [15:0] elapsed, sum_angle;
    logic [31:0] measured, di, integ_new, corr, rotor_new;
    logic signed [32:0] integ_sum;
    logic        pat_changed, pat_ok;
    logic [7:0]  phase_ofs;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign tbl_we      = in_fire && (i_in_data.opcode == OP_TABLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = r_out;

    hps_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(i_in_data.table_index),
        .i_wdata(i_in_data.table_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // transition decode and pll arithmetic
    always_comb begin
        elapsed     = r_in.timer_now - r_edge_time;
        pat_changed = (r_in.hall_pattern != r_prior);
        pat_ok      = (r_in.hall_pattern == next_pattern(r_prior));
        measured    = {8'd0, pattern_angle(r_in.hall_pattern), 8'd0};
        di          = r_prod[39:8];
        integ_sum   = $signed({r_integ[31], r_integ}) + $signed({di[31], di});
        if (integ_sum > INTEG_LIMIT) begin
            integ_new = 32'(INTEG_LIMIT);
        end else if (integ_sum < -INTEG_LIMIT) begin
            integ_new = 32'(-INTEG_LIMIT);
        end else begin
            integ_new = integ_sum[31:0];
        end
        if (r_integ_gain == 16'd0) begin
            integ_new = r_integ;
        end
        corr      = r_dp + integ_new;
        rotor_new = r_interp ? (r_edge_pos + r_prod[31:0]) : measured;
        sum_angle = rotor_new[23:8] + r_lead_angle + {r_ref_angle, 8'd0};
    end

    // table address per phase
    always_comb begin
        case (r_phase)
            2'd0:    phase_ofs = PHASE_A_OFS;
            2'd2:    phase_ofs = PHASE_C_OFS;
            default: phase_ofs = 8'd0;
        endcase
        base_addr = r_final[15:8] + phase_ofs;
        ram_raddr = (r_state == ST_RD0) ? base_addr + 8'd1 : base_addr;
    end

    // multiplier operand select
    always_comb begin
        case (r_state)
            ST_MULP: begin
                mul_a = $signed({r_err[31], r_err});
                mul_b = $signed({r_prop_gain[15], r_prop_gain});
            end
            ST_MULI: begin
                mul_a = $signed({r_err[31], r_err});
                mul_b = $signed({r_integ_gain[15], r_integ_gain});
            end
            ST_INTERP: begin
                mul_a = $signed({1'b0, r_vel});
                mul_b = $signed({1'b0, r_elapsed});
            end
            ST_LERP: begin
                mul_a = $signed({{16{r_diff[16]}}, r_diff});
                mul_b = $signed({9'd0, r_final[7:0]});
            end
            default: begin
                mul_a = $signed({{17{r_v[15]}}, r_v});
                mul_b = $signed({9'd0, r_in.drive_level});
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in_data.opcode == OP_TICK) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL:   n_state = (pat_changed && pat_ok) ? ST_MULP : ST_INTERP;
            ST_MULP:   n_state = ST_MULI;
            ST_MULI:   n_state = ST_CORR;
            ST_CORR:   n_state = ST_INTERP;
            ST_INTERP: n_state = ST_ANGLE;
            ST_ANGLE:  n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_RD0;
            ST_RD0:    n_state = ST_RD1;
            ST_RD1:    n_state = ST_LERP;
            ST_LERP:   n_state = ST_VSUM;
            ST_VSUM:   n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_STORE;
            ST_STORE:  n_state = (r_phase == 2'd2) ? ST_OUT : ST_ADDR;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prop_gain  <= 16'd5;
            r_integ_gain <= 16'd0;
            r_lead_angle <= 16'd0;
            r_ref_angle  <= 8'd66;
            r_pwm_mid    <= 16'd0;
            r_stall      <= 16'd4166;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                    CFG_LEAD_ANGLE: r_lead_angle <= i_cfg_data;
                    CFG_REF_ANGLE:  r_ref_angle  <= i_cfg_data[7:0];
                    CFG_PWM_MID:    r_pwm_mid    <= i_cfg_data;
                    CFG_STALL:      r_stall      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // estimator state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor          <= '0;
            r_edge_pos       <= '0;
            r_vel            <= '0;
            r_integ          <= '0;
            r_edge_time      <= '0;
            r_turn_ref_time  <= '0;
            r_turn_period    <= 16'hFFFF;
            r_prior          <= '0;
            r_turn_ref_valid <= 1'b0;
            r_interp         <= 1'b0;
        end else begin
            case (r_state)
                ST_EVAL: begin
                    if (pat_changed) begin
                        r_prior <= r_in.hall_pattern;
                        if (!pat_ok) begin
                            r_interp         <= 1'b0;
                            r_turn_ref_valid <= 1'b0;
                        end else if (r_in.hall_pattern == 3'd1) begin
                            if (r_turn_ref_valid) begin
                                r_turn_period <= r_edge_time - r_turn_ref_time;
                                r_interp      <= 1'b1;
                            end
                            r_turn_ref_valid <= 1'b1;
                            r_turn_ref_time  <= r_edge_time;
                        end
                    end else if (elapsed > r_stall) begin
                        r_interp         <= 1'b0;
                        r_turn_ref_valid <= 1'b0;
                        r_turn_period    <= 16'hFFFF;
                    end
                end
                ST_CORR: begin
                    r_integ     <= integ_new;
                    r_vel       <= r_vel + corr;
                    r_edge_pos  <= measured;
                    r_edge_time <= r_in.timer_now;
                end
                ST_ANGLE: r_rotor <= rotor_new;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_fire) begin
            r_in <= i_in_data;
        end
        case (r_state)
            ST_EVAL: begin
                r_elapsed <= elapsed;
                r_err     <= measured - r_rotor;
                r_edge_ok <= pat_changed && pat_ok && (r_in.hall_pattern == 3'd3);
            end
            ST_MULI:  r_dp <= r_prod[39:8];
            ST_ANGLE: begin
                r_final                 <= sum_angle;
                r_phase                 <= 2'd0;
                r_out.sine_mode         <= r_interp;
                r_out.period_ticks      <= r_turn_period;
                r_out.final_angle       <= sum_angle;
                r_out.lead_update_pulse <= r_edge_ok;
            end
            ST_RD0:   r_y0 <= ram_rdata;
            ST_RD1:   r_diff <= {ram_rdata[15], ram_rdata} - {r_y0[15], r_y0};
            ST_VSUM:  r_v <= r_y0 + r_prod[23:8];
            ST_STORE: begin
                case (r_phase)
                    2'd0:    r_out.pwm_phase_a <= r_pwm_mid + r_prod[23:8];
                    2'd1:    r_out.pwm_phase_b <= r_pwm_mid + r_prod[23:8];
                    default: r_out.pwm_phase_c <= r_pwm_mid + r_prod[23:8];
                endcase
                r_phase <= r_phase + 2'd1;
            end
            default: ;
        endcase
    end
endmodule

[rtl/core/hps_checker.sv]
`timescale 1ns / 1ps
module hps_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input hps_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input hps_pkg::t_out o_out_data
);
    import hps_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // no new beat is taken while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // table writes do not block the input
    a_tbl_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.opcode == OP_TABLE |=> o_in_ready)
        else $error("table write stalled input");

    // a control tick occupies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.opcode == OP_TICK
        |=> !o_in_ready && !o_out_valid)
        else $error("control tick not taken up");
endmodule

bind hall_pll_sine_pwm hps_checker u_hps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import hps_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    hall_pll_sine_pwm dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // hand-typed expectations for the directed rows that allow it
    typedef struct {
        logic        chk;
        logic [15:0] angle;
        logic [15:0] period;
        logic        mode;
        logic        pulse;
    } t_fixed;

    // predictor copy of registers and rotor state
    logic [15:0] m_prop, m_integ, m_lead, m_mid, m_stall;
    logic [7:0]  m_ref;
    logic [31:0] m_rpos, m_epos, m_vel;
    logic signed [31:0] m_integral;
    logic [15:0] m_etime, m_tref_time, m_period;
    logic [2:0]  m_prior;
    logic        m_tref_valid, m_interp;
    logic [15:0] m_table [TABLE_ENTRIES];

    t_out   pwm_expected [$];
    t_fixed fixed_expected [$];
    t_fixed next_fixed = '{1'b0, 16'd0, 16'd0, 1'b0, 1'b0};
    int   n_err = 0;
    int   n_beats = 0;
    int   n_ticks = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch beat %0d %s: got %h want %h", n_beats, what, got, want);
        n_err++;
    endtask

    function automatic longint floor8(input longint x);
        return x >>> 8;
    endfunction

    function automatic logic [15:0] phase_value(input logic [7:0] idx, input logic [7:0] frac,
                                                input logic [7:0] level);
        longint y0, y1, v, p;
        y0 = longint'($signed(m_table[idx]));
        y1 = longint'($signed(m_table[8'(idx + 8'd1)]));
        v = y0 + floor8((y1 - y0) * longint'(frac));
        v = longint'($signed(v[15:0]));
        p = longint'(m_mid) + floor8(v * longint'(level));
        return p[15:0];
    endfunction

    task automatic predict_reset();
        m_prop = 16'd5; m_integ = 0; m_lead = 0; m_ref = 8'd66; m_mid = 0; m_stall = 16'd4166;
        m_rpos = 0; m_epos = 0; m_vel = 0; m_integral = 0;
        m_etime = 0; m_tref_time = 0; m_period = 16'hffff;
        m_prior = 0; m_tref_valid = 0; m_interp = 0;
    endtask

    // advance the angle estimator for one tick and queue the result; a table beat only updates the table copy
    task automatic predict_beat(input t_in b);
        logic [15:0] elapsed, fa;
        logic [31:0] measured, corr;
        longint err, dp, di, sum;
        logic [63:0] prod;
        logic        pulse;
        t_out r;
        if (b.opcode == OP_TABLE) begin
            m_table[b.table_index] = b.table_value;
            return;
        end
        pulse = 1'b0;
        elapsed = b.timer_now - m_etime;
        if (b.hall_pattern != m_prior) begin
            if (b.hall_pattern != next_pattern(m_prior)) begin
                m_interp = 0;
                m_tref_valid = 0;
            end else begin
                measured = {8'd0, pattern_angle(b.hall_pattern), 8'd0};
                if (b.hall_pattern == 3'd1) begin
                    if (m_tref_valid) begin
                        m_period = m_etime - m_tref_time;
                        m_interp = 1;
                    end
                    m_tref_valid = 1;
                    m_tref_time = m_etime;
                end else if (b.hall_pattern == 3'd3) begin
                    pulse = 1'b1;
                end
                err = longint'($signed(measured - m_rpos));
                prod = 64'(floor8(err * longint'($signed(m_prop))));
                dp = longint'($signed(prod[31:0]));
                if (m_integ != 0) begin
                    prod = 64'(floor8(err * longint'($signed(m_integ))));
                    di = longint'($signed(prod[31:0]));
                    sum = longint'(m_integral) + di;
                    if (sum > 1048576) sum = 1048576;
                    if (sum < -1048576) sum = -1048576;
                    m_integral = 32'(sum);
                end
                corr = 32'(dp + longint'(m_integral));
                m_vel += corr;
                m_rpos += corr;
                m_epos = measured;
                m_etime = b.timer_now;
            end
            m_prior = b.hall_pattern;
        end else if (elapsed > m_stall) begin
            m_interp = 0;
            m_tref_valid = 0;
            m_period = 16'hffff;
        end
        if (m_interp) begin
            prod = 64'(m_vel) * 64'(elapsed);
            m_rpos = m_epos + prod[31:0];
        end else begin
            m_rpos = {8'd0, pattern_angle(b.hall_pattern), 8'd0};
        end
        fa = m_rpos[23:8] + m_lead + {m_ref, 8'd0};
        r.pwm_phase_a = phase_value(fa[15:8] + PHASE_A_OFS, fa[7:0], b.drive_level);
        r.pwm_phase_b = phase_value(fa[15:8], fa[7:0], b.drive_level);
        r.pwm_phase_c = phase_value(fa[15:8] + PHASE_C_OFS, fa[7:0], b.drive_level);
        r.sine_mode = m_interp;
        r.period_ticks = m_period;
        r.final_angle = fa;
        r.lead_update_pulse = pulse;
        pwm_expected.push_back(r);
        fixed_expected.push_back(next_fixed);
        next_fixed.chk = 1'b0;
        n_ticks++;
    endtask

    task automatic send_beat(input t_in b);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_in_data = b;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_beat(b);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic t_in tick(input logic [15:0] tm, input logic [2:0] pat,
                                 input logic [7:0] level);
        t_in b;
        b = '0;
        b.opcode = OP_TICK; b.timer_now = tm; b.hall_pattern = pat; b.drive_level = level;
        b.table_index = 8'($urandom); b.table_value = 16'($urandom);
        return b;
    endfunction

    task automatic drain();
        while (pwm_expected.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_PROP_GAIN:  m_prop = val;
            CFG_INTEG_GAIN: m_integ = val;
            CFG_LEAD_ANGLE: m_lead = val;
            CFG_REF_ANGLE:  m_ref = val[7:0];
            CFG_PWM_MID:    m_mid = val;
            CFG_STALL:      m_stall = val;
            default: ;
        endcase
    endtask

    // result side: random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 14) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    // result side: field compare
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_out   w;
            t_fixed f;
            n_beats++;
            if (pwm_expected.size() == 0) begin
                report_mismatch("unexpected result beat", o_out_data.final_angle, 16'd0);
            end else begin
                w = pwm_expected.pop_front();
                f = fixed_expected.pop_front();
                if (o_out_data.pwm_phase_a !== w.pwm_phase_a)
                    report_mismatch("pwm_phase_a", o_out_data.pwm_phase_a, w.pwm_phase_a);
                if (o_out_data.pwm_phase_b !== w.pwm_phase_b)
                    report_mismatch("pwm_phase_b", o_out_data.pwm_phase_b, w.pwm_phase_b);
                if (o_out_data.pwm_phase_c !== w.pwm_phase_c)
                    report_mismatch("pwm_phase_c", o_out_data.pwm_phase_c, w.pwm_phase_c);
                if (o_out_data.sine_mode !== w.sine_mode)
                    report_mismatch("sine_mode", 16'(o_out_data.sine_mode), 16'(w.sine_mode));
                if (o_out_data.period_ticks !== w.period_ticks)
                    report_mismatch("period_ticks", o_out_data.period_ticks, w.period_ticks);
                if (o_out_data.final_angle !== w.final_angle)
                    report_mismatch("final_angle", o_out_data.final_angle, w.final_angle);
                if (o_out_data.lead_update_pulse !== w.lead_update_pulse)
                    report_mismatch("lead_update_pulse", 16'(o_out_data.lead_update_pulse),
                                    16'(w.lead_update_pulse));
                // typed values for the rows that carry them
                if (f.chk) begin
                    if (o_out_data.final_angle !== f.angle)
                        report_mismatch("typed final_angle", o_out_data.final_angle, f.angle);
                    if (o_out_data.period_ticks !== f.period)
                        report_mismatch("typed period_ticks", o_out_data.period_ticks,
                                        f.period);
                    if (o_out_data.sine_mode !== f.mode)
                        report_mismatch("typed sine_mode", 16'(o_out_data.sine_mode),
                                        16'(f.mode));
                    if (o_out_data.lead_update_pulse !== f.pulse)
                        report_mismatch("typed lead_update_pulse",
                                        16'(o_out_data.lead_update_pulse), 16'(f.pulse));
                end
            end
        end
    end

    // directed table: one row per tick
    typedef struct {
        logic [15:0] tm;
        logic [2:0]  pat;
        logic [7:0]  level;
        t_fixed      want;
    } t_row;

    initial begin
        t_row   rows [$];
        t_in    b;
        t_fixed no_chk;
        logic [15:0] now;
        logic [2:0]  pat;
        int   step;
        predict_reset();
        no_chk = '{1'b0, 16'd0, 16'd0, 1'b0, 1'b0};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill the whole table first so no lookup hits an unwritten entry
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            b = '0;
            b.opcode = OP_TABLE; b.table_index = 8'(i);
            b.table_value = (i == 0) ? 16'h7fff : (i == 1) ? 16'h8000 : 16'($urandom);
            b.timer_now = 16'($urandom); b.hall_pattern = 3'($urandom);
            b.drive_level = 8'($urandom);
            send_beat(b);
        end

        // directed: clean turns, invalid jumps, patterns 0 and 7, stall, extremes
        // first row right after reset, second row the first valid edge into pattern 3
        rows = '{
            '{16'd0, 3'd0, 8'd0, '{1'b1, 16'h4200, 16'hffff, 1'b0, 1'b0}},
            '{16'd100, 3'd3, 8'd255, '{1'b1, 16'h8400, 16'hffff, 1'b0, 1'b1}},
            '{16'd200, 3'd2, 8'd128, no_chk}, '{16'd300, 3'd6, 8'd255, no_chk},
            '{16'd400, 3'd4, 8'd1, no_chk}, '{16'd500, 3'd5, 8'd255, no_chk},
            '{16'd600, 3'd1, 8'd200, no_chk}, '{16'd700, 3'd3, 8'd255, no_chk},
            '{16'd800, 3'd2, 8'd255, no_chk}, '{16'd900, 3'd6, 8'd255, no_chk},
            '{16'd1000, 3'd4, 8'd255, no_chk}, '{16'd1100, 3'd5, 8'd255, no_chk},
            '{16'd1200, 3'd1, 8'd255, no_chk}, '{16'd1250, 3'd1, 8'd255, no_chk},
            '{16'd1300, 3'd4, 8'd9, no_chk}, '{16'd1400, 3'd7, 8'd255, no_chk},
            '{16'd1500, 3'd1, 8'd0, no_chk}, '{16'hffff, 3'd1, 8'd255, no_chk},
            '{16'd0, 3'd0, 8'd255, no_chk}, '{16'd7, 3'd7, 8'd255, no_chk}
        };
        foreach (rows[i]) begin
            next_fixed = rows[i].want;
            send_beat(tick(rows[i].tm, rows[i].pat, rows[i].level));
        end
        drain();

        // random phases over several register settings
        now = 0; pat = 3'd1;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_cfg(CFG_PROP_GAIN, 16'h7fff); write_cfg(CFG_INTEG_GAIN, 16'h7fff);
                    write_cfg(CFG_LEAD_ANGLE, 16'h7fff); write_cfg(CFG_REF_ANGLE, 16'd255);
                    write_cfg(CFG_PWM_MID, 16'hffff); write_cfg(CFG_STALL, 16'd0);
                end
                1: begin
                    write_cfg(CFG_PROP_GAIN, 16'h8000); write_cfg(CFG_INTEG_GAIN, 16'h8000);
                    write_cfg(CFG_LEAD_ANGLE, 16'h8000); write_cfg(CFG_REF_ANGLE, 16'd0);
                    write_cfg(CFG_PWM_MID, 16'd0); write_cfg(CFG_STALL, 16'hffff);
                end
                default: begin
                    write_cfg(CFG_PROP_GAIN, 16'($urandom_range(0, 1024)));
                    write_cfg(CFG_INTEG_GAIN, 16'($urandom_range(0, 64)));
                    write_cfg(CFG_LEAD_ANGLE, 16'($urandom));
                    write_cfg(CFG_REF_ANGLE, 16'($urandom_range(0, 255)));
                    write_cfg(CFG_PWM_MID, 16'($urandom));
                    write_cfg(CFG_STALL, 16'($urandom_range(200, 6000)));
                end
            endcase
            for (int k = 0; k < 55; k++) begin
                step = $urandom_range(0, 19);
                if (step < 14) begin
                    // mostly clean rotation with ticks between edges
                    now += 16'($urandom_range(1, 300));
                    if ($urandom_range(0, 2) == 0) pat = next_pattern(pat);
                    send_beat(tick(now, pat, 8'($urandom)));
                end else if (step < 17) begin
                    now += 16'($urandom);
                    pat = 3'($urandom);
                    send_beat(tick(now, pat, 8'($urandom)));
                end else if (step < 19) begin
                    b = '0;
                    b.opcode = OP_TABLE; b.table_index = 8'($urandom);
                    b.table_value = 16'($urandom); b.timer_now = 16'($urandom);
                    send_beat(b);
                end else begin
                    now += 16'($urandom_range(4000, 65535));
                    send_beat(tick(now, pat, 8'($urandom)));
                end
            end
            drain();
        end

        $display("covered %0d control ticks over five register settings plus table loads",
                 n_ticks);
        $display("with clean turns, bad transitions, stalls and random handshake stalls");
        if (n_err == 0 && pwm_expected.size() == 0)
            $display("hall_pll_sine_pwm verification clean");
        else
            $display("hall_pll_sine_pwm verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("hall_pll_sine_pwm verification failed");
        $finish;
    end
endmodule
